// ===== rtl/qvfc_pkg.sv =====
// ============================================================================
// qvfc_pkg
// Shared constants and types of the quaternion velocity frame converter.
// ============================================================================
package qvfc_pkg;

    localparam int QUAT_FRAC_BITS = 29;
    localparam int SQRT_STEPS     = 32;
    localparam int DIV_STEPS      = 32;
    localparam int DIVN_W         = 33 + QUAT_FRAC_BITS;
    localparam int DDEN_W         = 33 + DIV_STEPS;
    localparam int C_W            = 37;
    localparam int T_W            = 42;
    localparam int O_W            = 44;

    localparam logic [31:0] UNIT_ONE = 32'(64'd1 << QUAT_FRAC_BITS);

    typedef enum logic [1:0] {
        REG_VEL_IS_BODY,
        REG_OUT_NED,
        REG_USE_HDR,
        REG_TIME_OFS
    } reg_idx_t;

    typedef logic [3:0][31:0] quad_t;

    typedef struct packed {
        logic signed [31:0] vel_a;
        logic signed [31:0] vel_b;
        logic signed [31:0] vel_c;
        logic [62:0]        now;
        logic [62:0]        sample;
        logic               rotate;
        logic               frame;
    } side_t;

    typedef struct packed {
        quad_t      mag;
        logic [3:0] neg;
        logic       degen;
    } quat_t;

    typedef struct packed {
        quad_t              unit;
        logic signed [31:0] vel_a;
        logic signed [31:0] vel_b;
        logic signed [31:0] vel_c;
        logic               frame;
        logic               degen;
        logic [62:0]        now;
        logic [62:0]        sample;
    } res_t;

endpackage

// ===== rtl/qvfc_norm.sv =====
// ============================================================================
// qvfc_norm
// Magnitude, block scaling, squaring and sum of squares of the quaternion.
// ============================================================================
module qvfc_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  qvfc_pkg::quad_t   quat_raw,
    input  qvfc_pkg::side_t   side_in,
    output logic              out_valid,
    output logic [63:0]       sum_sq,
    output qvfc_pkg::quat_t   quat_out,
    output qvfc_pkg::side_t   side_out
);

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    qvfc_pkg::quad_t mag1_reg, mag1_next;
    logic [3:0]      neg1_reg, neg1_next;
    qvfc_pkg::quat_t quat2_reg, quat2_next, quat3_reg, quat4_reg;
    logic [3:0][63:0] sq3_reg, sq3_next;
    logic [63:0]     sum4_reg, sum4_next;
    qvfc_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;
    logic [31:0]     mx;
    logic [4:0]      sh;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg1_next[i] = quat_raw[i][31];
            mag1_next[i] = quat_raw[i][31] ? (~quat_raw[i] + 32'd1) : quat_raw[i];
        end
    end

    always_comb
    begin
        mx = mag1_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (mag1_reg[i] > mx)
            begin
                mx = mag1_reg[i];
            end
        end
        sh = '0;
        for (int k = 0; k < 30; k++)
        begin
            if (mx[k])
            begin
                sh = 5'(30 - k);
            end
        end
        if (mx[31] | mx[30])
        begin
            sh = '0;
        end
        quat2_next.neg   = neg1_reg;
        quat2_next.degen = (mx == '0);
        for (int i = 0; i < 4; i++)
        begin
            quat2_next.mag[i] = mag1_reg[i] << sh;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq3_next[i] = 64'(quat2_reg.mag[i]) * 64'(quat2_reg.mag[i]);
        end
        sum4_next = (sq3_reg[0] >> 2) + (sq3_reg[1] >> 2) + (sq3_reg[2] >> 2)
                  + (sq3_reg[3] >> 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            side1_reg <= side_in;
            quat2_reg <= quat2_next;
            side2_reg <= side1_reg;
            sq3_reg   <= sq3_next;
            quat3_reg <= quat2_reg;
            side3_reg <= side2_reg;
            sum4_reg  <= sum4_next;
            quat4_reg <= quat3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign sum_sq    = sum4_reg;
    assign quat_out  = quat4_reg;
    assign side_out  = side4_reg;

endmodule

// ===== rtl/qvfc_sqrt.sv =====
// ============================================================================
// qvfc_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module qvfc_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [63:0]       radicand,
    input  qvfc_pkg::quat_t   quat_in,
    input  qvfc_pkg::side_t   side_in,
    output logic              out_valid,
    output logic [31:0]       root,
    output qvfc_pkg::quat_t   quat_out,
    output qvfc_pkg::side_t   side_out
);

    logic            valid_reg [qvfc_pkg::SQRT_STEPS];
    logic [63:0]     x_reg     [qvfc_pkg::SQRT_STEPS];
    logic [35:0]     rem_reg   [qvfc_pkg::SQRT_STEPS];
    logic [31:0]     root_reg  [qvfc_pkg::SQRT_STEPS];
    qvfc_pkg::quat_t quat_reg  [qvfc_pkg::SQRT_STEPS];
    qvfc_pkg::side_t side_reg  [qvfc_pkg::SQRT_STEPS];

    for (genvar k = 0; k < qvfc_pkg::SQRT_STEPS; k++)
    begin : g_step
        logic            v_in;
        logic [63:0]     x_in;
        logic [35:0]     rem_in;
        logic [31:0]     root_in;
        qvfc_pkg::quat_t q_in;
        qvfc_pkg::side_t s_in;
        logic [35:0]     rem_sh, test, rem_next;
        logic [31:0]     root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign q_in    = quat_in;
            assign s_in    = side_in;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign q_in    = quat_reg[k-1];
            assign s_in    = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[33:0], x_in[63:62]};
            test   = {2'b00, root_in, 2'b01};
            if (rem_sh >= test)
            begin
                rem_next  = rem_sh - test;
                root_next = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]    <= x_in << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                quat_reg[k] <= q_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[qvfc_pkg::SQRT_STEPS-1];
    assign root      = root_reg[qvfc_pkg::SQRT_STEPS-1];
    assign quat_out  = quat_reg[qvfc_pkg::SQRT_STEPS-1];
    assign side_out  = side_reg[qvfc_pkg::SQRT_STEPS-1];

endmodule

// ===== rtl/qvfc_div.sv =====
// ============================================================================
// qvfc_div
// Four-lane pipelined divider that scales the quaternion by its norm,
// followed by sign restore, saturation and the identity fallback.
// ============================================================================
module qvfc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [31:0]       norm,
    input  qvfc_pkg::quat_t   quat_in,
    input  qvfc_pkg::side_t   side_in,
    output logic              out_valid,
    output qvfc_pkg::quad_t   unit,
    output logic              degen,
    output qvfc_pkg::side_t   side_out
);

    typedef logic [3:0][qvfc_pkg::DIVN_W-1:0] rem4_t;

    logic            s_valid_reg;
    rem4_t           s_rem_reg, s_rem_next;
    logic [32:0]     s_den_reg;
    qvfc_pkg::quat_t s_quat_reg;
    qvfc_pkg::side_t s_side_reg;

    logic            valid_reg [qvfc_pkg::DIV_STEPS];
    rem4_t           rem_reg   [qvfc_pkg::DIV_STEPS];
    qvfc_pkg::quad_t quo_reg   [qvfc_pkg::DIV_STEPS];
    logic [32:0]     den_reg   [qvfc_pkg::DIV_STEPS];
    qvfc_pkg::quat_t quat_reg  [qvfc_pkg::DIV_STEPS];
    qvfc_pkg::side_t side_reg  [qvfc_pkg::DIV_STEPS];

    logic            f_valid_reg;
    qvfc_pkg::quad_t f_unit_reg, f_unit_next;
    logic            f_degen_reg;
    qvfc_pkg::side_t f_side_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s_rem_next[i] = (qvfc_pkg::DIVN_W'(quat_in.mag[i]) << qvfc_pkg::QUAT_FRAC_BITS)
                          + qvfc_pkg::DIVN_W'(norm);
        end
    end

    for (genvar k = 0; k < qvfc_pkg::DIV_STEPS; k++)
    begin : g_step
        logic                       v_in;
        rem4_t                      rem_in, rem_next;
        qvfc_pkg::quad_t            quo_in, quo_next;
        logic [32:0]                den_in;
        qvfc_pkg::quat_t            q_in;
        qvfc_pkg::side_t            s_in;
        logic [qvfc_pkg::DDEN_W-1:0] dsh;

        if (k == 0)
        begin : g_first
            assign v_in   = s_valid_reg;
            assign rem_in = s_rem_reg;
            assign quo_in = '0;
            assign den_in = s_den_reg;
            assign q_in   = s_quat_reg;
            assign s_in   = s_side_reg;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = quat_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        always_comb
        begin
            dsh = qvfc_pkg::DDEN_W'(den_in) << (qvfc_pkg::DIV_STEPS - 1 - k);
            for (int i = 0; i < 4; i++)
            begin
                if (qvfc_pkg::DDEN_W'(rem_in[i]) >= dsh)
                begin
                    rem_next[i] = rem_in[i] - qvfc_pkg::DIVN_W'(dsh);
                    quo_next[i] = quo_in[i] | (32'd1 << (qvfc_pkg::DIV_STEPS - 1 - k));
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = quo_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_in;
                quat_reg[k] <= q_in;
                side_reg[k] <= s_in;
            end
        end
    end

    always_comb
    begin
        logic signed [33:0] sv;
        for (int i = 0; i < 4; i++)
        begin
            sv = $signed({2'b00, quo_reg[qvfc_pkg::DIV_STEPS-1][i]});
            if (quat_reg[qvfc_pkg::DIV_STEPS-1].neg[i])
            begin
                sv = -sv;
            end
            if (sv > 34'sd2147483647)
            begin
                f_unit_next[i] = 32'h7FFF_FFFF;
            end
            else if (sv < -34'sd2147483648)
            begin
                f_unit_next[i] = 32'h8000_0000;
            end
            else
            begin
                f_unit_next[i] = sv[31:0];
            end
        end
        if (quat_reg[qvfc_pkg::DIV_STEPS-1].degen)
        begin
            f_unit_next    = '0;
            f_unit_next[0] = qvfc_pkg::UNIT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s_valid_reg <= in_valid;
            f_valid_reg <= valid_reg[qvfc_pkg::DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_rem_reg   <= s_rem_next;
            s_den_reg   <= {norm, 1'b0};
            s_quat_reg  <= quat_in;
            s_side_reg  <= side_in;
            f_unit_reg  <= f_unit_next;
            f_degen_reg <= quat_reg[qvfc_pkg::DIV_STEPS-1].degen;
            f_side_reg  <= side_reg[qvfc_pkg::DIV_STEPS-1];
        end
    end

    assign out_valid = f_valid_reg;
    assign unit      = f_unit_reg;
    assign degen     = f_degen_reg;
    assign side_out  = f_side_reg;

endmodule

// ===== rtl/qvfc_rot.sv =====
// ============================================================================
// qvfc_rot
// Rotation of the velocity by the unit quaternion through two cross
// products, with saturation and selection of the output velocity.
// ============================================================================
module qvfc_rot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  qvfc_pkg::quad_t   unit_in,
    input  logic              degen_in,
    input  qvfc_pkg::side_t   side_in,
    output logic              out_valid,
    output qvfc_pkg::res_t    res
);

    localparam logic signed [64:0] HALF1 = 65'sd1 <<< (qvfc_pkg::QUAT_FRAC_BITS - 1);
    localparam logic signed [69:0] HALF2 = 70'sd1 <<< (qvfc_pkg::QUAT_FRAC_BITS - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [63:0] p1_reg [6];
    logic signed [63:0] p1_next [6];
    logic signed [qvfc_pkg::C_W-1:0] c2_reg [3];
    logic signed [qvfc_pkg::C_W-1:0] c2_next [3];
    logic signed [68:0] p3_reg [6];
    logic signed [68:0] p3_next [6];
    logic signed [68:0] d3_reg [3];
    logic signed [68:0] d3_next [3];
    logic signed [qvfc_pkg::T_W-1:0] t4_reg [3];
    logic signed [qvfc_pkg::T_W-1:0] t4_next [3];
    qvfc_pkg::quad_t u1_reg, u2_reg, u3_reg, u4_reg;
    logic            g1_reg, g2_reg, g3_reg, g4_reg;
    qvfc_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg;
    qvfc_pkg::res_t  res_reg, res_next;

    always_comb
    begin
        logic signed [31:0] qx, qy, qz;
        qx = $signed(unit_in[1]);
        qy = $signed(unit_in[2]);
        qz = $signed(unit_in[3]);
        p1_next[0] = 64'(qy) * 64'(side_in.vel_c);
        p1_next[1] = 64'(qz) * 64'(side_in.vel_b);
        p1_next[2] = 64'(qz) * 64'(side_in.vel_a);
        p1_next[3] = 64'(qx) * 64'(side_in.vel_c);
        p1_next[4] = 64'(qx) * 64'(side_in.vel_b);
        p1_next[5] = 64'(qy) * 64'(side_in.vel_a);
    end

    always_comb
    begin
        logic signed [64:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d = 65'(p1_reg[2*i]) - 65'(p1_reg[2*i+1]) + HALF1;
            d = d >>> qvfc_pkg::QUAT_FRAC_BITS;
            c2_next[i] = qvfc_pkg::C_W'(d);
        end
    end

    always_comb
    begin
        logic signed [31:0] qw, qx, qy, qz;
        qw = $signed(u2_reg[0]);
        qx = $signed(u2_reg[1]);
        qy = $signed(u2_reg[2]);
        qz = $signed(u2_reg[3]);
        p3_next[0] = 69'(qy) * 69'(c2_reg[2]);
        p3_next[1] = 69'(qz) * 69'(c2_reg[1]);
        p3_next[2] = 69'(qz) * 69'(c2_reg[0]);
        p3_next[3] = 69'(qx) * 69'(c2_reg[2]);
        p3_next[4] = 69'(qx) * 69'(c2_reg[1]);
        p3_next[5] = 69'(qy) * 69'(c2_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            d3_next[i] = 69'(qw) * 69'(c2_reg[i]);
        end
    end

    always_comb
    begin
        logic signed [69:0] wd, dd;
        for (int i = 0; i < 3; i++)
        begin
            wd = (70'(p3_reg[2*i]) - 70'(p3_reg[2*i+1]) + HALF2) >>> qvfc_pkg::QUAT_FRAC_BITS;
            dd = (70'(d3_reg[i]) + HALF2) >>> qvfc_pkg::QUAT_FRAC_BITS;
            t4_next[i] = qvfc_pkg::T_W'(wd) + qvfc_pkg::T_W'(dd);
        end
    end

    always_comb
    begin
        logic signed [qvfc_pkg::O_W-1:0] o;
        logic signed [31:0] vin [3];
        logic signed [31:0] vo  [3];
        vin[0] = s4_reg.vel_a;
        vin[1] = s4_reg.vel_b;
        vin[2] = s4_reg.vel_c;
        for (int i = 0; i < 3; i++)
        begin
            o = qvfc_pkg::O_W'(vin[i]) + (qvfc_pkg::O_W'(t4_reg[i]) <<< 1);
            if (!s4_reg.rotate)
            begin
                vo[i] = vin[i];
            end
            else if (o > 44'sd2147483647)
            begin
                vo[i] = 32'sh7FFF_FFFF;
            end
            else if (o < -44'sd2147483648)
            begin
                vo[i] = 32'sh8000_0000;
            end
            else
            begin
                vo[i] = o[31:0];
            end
        end
        res_next.unit   = u4_reg;
        res_next.vel_a  = vo[0];
        res_next.vel_b  = vo[1];
        res_next.vel_c  = vo[2];
        res_next.frame  = s4_reg.frame;
        res_next.degen  = g4_reg;
        res_next.now    = s4_reg.now;
        res_next.sample = s4_reg.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= p1_next;
            u1_reg  <= unit_in;
            g1_reg  <= degen_in;
            s1_reg  <= side_in;
            c2_reg  <= c2_next;
            u2_reg  <= u1_reg;
            g2_reg  <= g1_reg;
            s2_reg  <= s1_reg;
            p3_reg  <= p3_next;
            d3_reg  <= d3_next;
            u3_reg  <= u2_reg;
            g3_reg  <= g2_reg;
            s3_reg  <= s2_reg;
            t4_reg  <= t4_next;
            u4_reg  <= u3_reg;
            g4_reg  <= g3_reg;
            s4_reg  <= s3_reg;
            res_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/quat_velocity_frame_convert.sv =====
// ============================================================================
// quat_velocity_frame_convert
// Normalizes an attitude quaternion, rotates a body velocity into NED and
// corrects the sample timestamp, one odometry sample per beat.
// ============================================================================
// The block takes one input beat per clock cycle while in_ready is high and
// returns one result beat for each, in order. Most of the pipeline is the
// bit-per-stage square root (32 stages) and divider (34 stages) that normalize
// the quaternion; the whole pipeline holds while a result beat waits on
// out_ready, so in_ready is low only in that case.
module quat_velocity_frame_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    input  logic signed [31:0] vel_in_a,
    input  logic signed [31:0] vel_in_b,
    input  logic signed [31:0] vel_in_c,
    input  logic [62:0]        now_us,
    input  logic [62:0]        stamp_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] unit_w,
    output logic signed [31:0] unit_x,
    output logic signed [31:0] unit_y,
    output logic signed [31:0] unit_z,
    output logic signed [31:0] vel_out_a,
    output logic signed [31:0] vel_out_b,
    output logic signed [31:0] vel_out_c,
    output logic               vel_frame,
    output logic               degenerate_quat,
    output logic [62:0]        time_now_out,
    output logic [62:0]        time_sample_out
);

    logic        vel_body_reg, out_ned_reg, use_hdr_reg;
    logic [32:0] ofs_reg;
    logic        adv, cfg_wr;
    qvfc_pkg::side_t side_in;
    qvfc_pkg::quad_t quat_raw;

    logic            n_valid;
    logic [63:0]     n_sum;
    qvfc_pkg::quat_t n_quat;
    qvfc_pkg::side_t n_side;
    logic            s_valid;
    logic [31:0]     s_root;
    qvfc_pkg::quat_t s_quat;
    qvfc_pkg::side_t s_side;
    logic            d_valid;
    qvfc_pkg::quad_t d_unit;
    logic            d_degen;
    qvfc_pkg::side_t d_side;
    logic            r_valid;
    qvfc_pkg::res_t  r_res;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_body_reg <= 1'b1;
            out_ned_reg  <= 1'b1;
            use_hdr_reg  <= 1'b1;
            ofs_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            case (qvfc_pkg::reg_idx_t'(paddr[4:3]))
                qvfc_pkg::REG_VEL_IS_BODY: vel_body_reg <= pwdata[0];
                qvfc_pkg::REG_OUT_NED:     out_ned_reg  <= pwdata[0];
                qvfc_pkg::REG_USE_HDR:     use_hdr_reg  <= pwdata[0];
                qvfc_pkg::REG_TIME_OFS:    ofs_reg      <= pwdata[32:0];
                default:                   ofs_reg      <= ofs_reg;
            endcase
        end
    end

    always_comb
    begin
        case (qvfc_pkg::reg_idx_t'(paddr[4:3]))
            qvfc_pkg::REG_VEL_IS_BODY: prdata = {63'd0, vel_body_reg};
            qvfc_pkg::REG_OUT_NED:     prdata = {63'd0, out_ned_reg};
            qvfc_pkg::REG_USE_HDR:     prdata = {63'd0, use_hdr_reg};
            qvfc_pkg::REG_TIME_OFS:    prdata = {{31{ofs_reg[32]}}, ofs_reg};
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        logic [63:0] stamp64, corr;
        logic [32:0] ofs_mag;
        stamp64 = {1'b0, stamp_us};
        ofs_mag = ~ofs_reg + 33'd1;
        if (!ofs_reg[32])
        begin
            corr = (stamp64 > 64'(ofs_reg)) ? stamp64 - 64'(ofs_reg) : '0;
        end
        else
        begin
            corr = stamp64 + 64'(ofs_mag);
        end
        side_in.sample = now_us;
        if (use_hdr_reg && (stamp_us != '0))
        begin
            side_in.sample = (corr > {1'b0, now_us}) ? now_us : corr[62:0];
        end
        side_in.vel_a  = vel_in_a;
        side_in.vel_b  = vel_in_b;
        side_in.vel_c  = vel_in_c;
        side_in.now    = now_us;
        side_in.rotate = out_ned_reg & vel_body_reg;
        side_in.frame  = ~out_ned_reg & vel_body_reg;
    end

    assign quat_raw = {quat_z, quat_y, quat_x, quat_w};
    assign adv      = ~r_valid | out_ready;
    assign in_ready = adv;

    qvfc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .quat_raw  (quat_raw),
        .side_in   (side_in),
        .out_valid (n_valid),
        .sum_sq    (n_sum),
        .quat_out  (n_quat),
        .side_out  (n_side)
    );

    qvfc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n_valid),
        .radicand  (n_sum),
        .quat_in   (n_quat),
        .side_in   (n_side),
        .out_valid (s_valid),
        .root      (s_root),
        .quat_out  (s_quat),
        .side_out  (s_side)
    );

    qvfc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .norm      (s_root),
        .quat_in   (s_quat),
        .side_in   (s_side),
        .out_valid (d_valid),
        .unit      (d_unit),
        .degen     (d_degen),
        .side_out  (d_side)
    );

    qvfc_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid),
        .unit_in   (d_unit),
        .degen_in  (d_degen),
        .side_in   (d_side),
        .out_valid (r_valid),
        .res       (r_res)
    );

    assign out_valid       = r_valid;
    assign unit_w          = r_res.unit[0];
    assign unit_x          = r_res.unit[1];
    assign unit_y          = r_res.unit[2];
    assign unit_z          = r_res.unit[3];
    assign vel_out_a       = r_res.vel_a;
    assign vel_out_b       = r_res.vel_b;
    assign vel_out_c       = r_res.vel_c;
    assign vel_frame       = r_res.frame;
    assign degenerate_quat = r_res.degen;
    assign time_now_out    = r_res.now;
    assign time_sample_out = r_res.sample;

endmodule

// ===== rtl/qvfc_check.sv =====
// ============================================================================
// qvfc_check
// Port-level checks of the quaternion velocity frame converter.
// ============================================================================
module qvfc_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] unit_w,
    input logic signed [31:0] unit_x,
    input logic signed [31:0] unit_y,
    input logic signed [31:0] unit_z,
    input logic               degenerate_quat,
    input logic [62:0]        time_now_out,
    input logic [62:0]        time_sample_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_w) && $stable(time_sample_out))
        else $error("result beat changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output backpressure");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate_quat |-> unit_w == qvfc_pkg::UNIT_ONE && unit_x == 0
        && unit_y == 0 && unit_z == 0)
        else $error("degenerate quaternion not replaced by identity");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> time_sample_out <= time_now_out)
        else $error("sample time ahead of now");

endmodule

bind quat_velocity_frame_convert qvfc_check u_qvfc_check (.*);
